// ===== hdl/rrs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrs_pkg
// Shared types and constants of the round-robin scheduler with sleep.
// ----------------------------------------------------------------------------
package rrs_pkg;

  localparam logic [2:0] REQ_TICK     = 3'd0;
  localparam logic [2:0] REQ_SCHEDULE = 3'd1;
  localparam logic [2:0] REQ_ADD      = 3'd2;
  localparam logic [2:0] REQ_REMOVE   = 3'd3;
  localparam logic [2:0] REQ_SLEEP    = 3'd4;

  localparam logic CFG_SLICE_LEN = 1'b0;
  localparam logic CFG_TPS       = 1'b1;

  localparam logic [15:0] SLICE_LEN_RST = 16'd10;
  localparam logic [9:0]  TPS_RST       = 10'd100;
  localparam logic [15:0] SLICE_MAX     = 16'hFFFF;

  localparam logic [0:0] STATUS_OK      = 1'b0;
  localparam logic [0:0] STATUS_NOT_SCH = 1'b1;

  // One entry of the per-task counter memory.
  typedef struct packed {
    logic [31:0] run;
    logic [15:0] slice;
    logic [20:0] sleep;
  } task_entry_t;

endpackage
`default_nettype wire

// ===== hdl/round_robin_scheduler_with_sleep.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// round_robin_scheduler_with_sleep
// Round-robin time-slice task scheduler with sleeping tasks.
// ----------------------------------------------------------------------------
// One request beat (tick, schedule, add, remove or sleep) produces one result
// beat giving the active task, its run-tick total and a status bit. The
// block works on one request at a time and the time per request is set by
// the list walks through the list memory, which has one read and one write
// port. A tick walks the sleep list, after counting up the active task
// when one is active; a schedule walks the ready queue when its head is
// popped; a remove walks each list; a sleep walks the ready queue, and the
// sleep list as well when it has to be searched. The result sits in an
// output register, so a new request is taken while the previous result
// beat is still waiting to be accepted; a second result waits in the
// sequencer until the first has gone. Per-task counters live in a second
// memory whose entries read as zero until first written, so no clearing
// pass is needed after reset.
// ----------------------------------------------------------------------------
module round_robin_scheduler_with_sleep #(
  parameter int MAX_TASKS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_idx,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [3:0]  in_process_id,
  input  wire logic [9:0]  in_sleep_seconds,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_active_valid,
  output logic [3:0]       out_active_id,
  output logic             out_status,
  output logic [31:0]      out_active_run_ticks
);

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int LA_W  = $clog2(2 * MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int TM_W  = $bits(rrs_pkg::task_entry_t);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_TASKS);

  // Sequencer states, one-hot.
  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_TK_WR  = 18'h00002,
    S_SL_LRD = 18'h00004,
    S_SL_TRD = 18'h00008,
    S_SL_WR  = 18'h00010,
    S_SC_CHK = 18'h00020,
    S_SC_POP = 18'h00040,
    S_SC_SET = 18'h00080,
    S_LP_RD  = 18'h00100,
    S_LP_CHK = 18'h00200,
    S_RM2    = 18'h00400,
    S_SP_WR  = 18'h00800,
    S_SP2    = 18'h01000,
    S_SP3    = 18'h02000,
    S_OUT_RD = 18'h04000,
    S_FIN    = 18'h08000,
    S_SPARE0 = 18'h10000,
    S_SPARE1 = 18'h20000
  } state_t;

  // The ready queue occupies list entries from zero, the sleep list the
  // entries from MAX_TASKS upwards.
  function automatic logic [LA_W-1:0] laddr(input logic sel, input logic [CNT_W-1:0] k);
    laddr = LA_W'(k) + (sel ? LA_W'(MAX_TASKS) : LA_W'(0));
  endfunction

  state_t              state_r, state_nxt, ret_r, ret_nxt;
  logic                cv_r, cv_nxt;
  logic [3:0]          cur_r, cur_nxt;
  logic [CNT_W-1:0]    rcnt_r, rcnt_nxt, scnt_r, scnt_nxt;
  logic [15:0]         sl_len_r;
  logic [9:0]          tps_r;
  logic [3:0]          key_r, key_nxt;
  logic [19:0]         prod_r, prod_nxt;
  logic [CNT_W-1:0]    i_r, i_nxt, kept_r, kept_nxt, k_r, k_nxt;
  logic [3:0]          sid_r, sid_nxt, head_r, head_nxt;
  logic                found_r, found_nxt, pop_r, pop_nxt, lsel_r, lsel_nxt;
  logic                status_r, status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                oav_r, oav_nxt;
  logic [3:0]          oid_r, oid_nxt;
  logic                ost_r, ost_nxt;
  logic [31:0]         orun_r, orun_nxt;
  logic [MAX_TASKS-1:0] tv_r;
  logic                tv_q;

  // Memory ports.
  logic                 lm_we, lm_re;
  logic [LA_W-1:0]      lm_waddr, lm_raddr;
  logic [3:0]           lm_wdata, lm_q;
  logic                 tm_we, tm_re;
  logic [IDX_W-1:0]     tm_waddr, tm_raddr;
  rrs_pkg::task_entry_t tm_wdata, tm_q, tq;

  logic                 id_ok;
  logic [CNT_W-1:0]     lp_cnt;
  logic [20:0]          sl_dec;

  rrs_ram #(.W(4), .D(2 * MAX_TASKS)) u_list_ram (
    .clk   (clk),
    .we    (lm_we),
    .waddr (lm_waddr),
    .wdata (lm_wdata),
    .re    (lm_re),
    .raddr (lm_raddr),
    .rdata (lm_q)
  );

  rrs_ram #(.W(TM_W), .D(MAX_TASKS)) u_task_ram (
    .clk   (clk),
    .we    (tm_we),
    .waddr (tm_waddr),
    .wdata (tm_wdata),
    .re    (tm_re),
    .raddr (tm_raddr),
    .rdata (tm_q)
  );

  // An entry never written reads as all-zero counters.
  assign tq       = tv_q ? tm_q : '0;
  assign id_ok    = (32'(in_process_id) < MAX_TASKS);
  assign lp_cnt   = lsel_r ? scnt_r : rcnt_r;
  assign sl_dec   = tq.sleep - 21'd1;
  assign in_ready = (state_r == S_IDLE);

  assign out_valid            = out_valid_r;
  assign out_active_valid     = oav_r;
  assign out_active_id        = oid_r;
  assign out_status           = ost_r;
  assign out_active_run_ticks = orun_r;

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    cv_nxt        = cv_r;
    cur_nxt       = cur_r;
    rcnt_nxt      = rcnt_r;
    scnt_nxt      = scnt_r;
    key_nxt       = key_r;
    prod_nxt      = prod_r;
    i_nxt         = i_r;
    kept_nxt      = kept_r;
    k_nxt         = k_r;
    sid_nxt       = sid_r;
    head_nxt      = head_r;
    found_nxt     = found_r;
    pop_nxt       = pop_r;
    lsel_nxt      = lsel_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_ready;
    oav_nxt       = oav_r;
    oid_nxt       = oid_r;
    ost_nxt       = ost_r;
    orun_nxt      = orun_r;
    lm_we         = 1'b0;
    lm_waddr      = '0;
    lm_wdata      = '0;
    lm_re         = 1'b0;
    lm_raddr      = '0;
    tm_we         = 1'b0;
    tm_waddr      = IDX_W'(cur_r);
    tm_wdata      = tq;
    tm_re         = 1'b0;
    tm_raddr      = IDX_W'(cur_r);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt    = in_process_id;
          status_nxt = rrs_pkg::STATUS_OK;
          prod_nxt   = tps_r * in_sleep_seconds;
          state_nxt  = S_OUT_RD;
          case (in_req_type)
            rrs_pkg::REQ_TICK: begin
              i_nxt    = '0;
              kept_nxt = '0;
              if (cv_r) begin
                tm_re     = 1'b1;
                state_nxt = S_TK_WR;
              end else begin
                state_nxt = S_SL_LRD;
              end
            end
            rrs_pkg::REQ_SCHEDULE: begin
              if (cv_r) begin
                tm_re     = 1'b1;
                state_nxt = S_SC_CHK;
              end else begin
                state_nxt = S_SC_POP;
              end
            end
            rrs_pkg::REQ_ADD: begin
              if (id_ok && rcnt_r < CNT_FULL) begin
                lm_we    = 1'b1;
                lm_waddr = laddr(1'b0, rcnt_r);
                lm_wdata = in_process_id;
                rcnt_nxt = rcnt_r + 1'b1;
              end
            end
            rrs_pkg::REQ_REMOVE: begin
              if (id_ok) begin
                if (cv_r && cur_r == in_process_id) begin
                  cv_nxt = 1'b0;
                end
                lsel_nxt  = 1'b0;
                pop_nxt   = 1'b0;
                k_nxt     = '0;
                found_nxt = 1'b0;
                ret_nxt   = S_RM2;
                state_nxt = S_LP_RD;
              end
            end
            rrs_pkg::REQ_SLEEP: begin
              if (id_ok) begin
                tm_re     = 1'b1;
                tm_raddr  = IDX_W'(in_process_id);
                state_nxt = S_SP_WR;
              end
            end
            default: begin
              state_nxt = S_OUT_RD;
            end
          endcase
        end
      end

      // Tick: count up the active task.
      S_TK_WR: begin
        tm_we          = 1'b1;
        tm_wdata.run   = tq.run + 32'd1;
        tm_wdata.slice = (tq.slice == rrs_pkg::SLICE_MAX) ? tq.slice : tq.slice + 16'd1;
        state_nxt      = S_SL_LRD;
      end

      // Tick: walk the sleep list, compacting the sleepers that stay.
      S_SL_LRD: begin
        if (i_r < scnt_r) begin
          lm_re     = 1'b1;
          lm_raddr  = laddr(1'b1, i_r);
          state_nxt = S_SL_TRD;
        end else begin
          scnt_nxt  = kept_r;
          state_nxt = S_OUT_RD;
        end
      end
      S_SL_TRD: begin
        sid_nxt   = lm_q;
        tm_re     = 1'b1;
        tm_raddr  = IDX_W'(lm_q);
        state_nxt = S_SL_WR;
      end
      S_SL_WR: begin
        tm_we          = 1'b1;
        tm_waddr       = IDX_W'(sid_r);
        tm_wdata.sleep = sl_dec;
        if (sl_dec == 21'd0 || sl_dec[20]) begin
          if (rcnt_r < CNT_FULL) begin
            lm_we    = 1'b1;
            lm_waddr = laddr(1'b0, rcnt_r);
            lm_wdata = sid_r;
            rcnt_nxt = rcnt_r + 1'b1;
          end
        end else begin
          lm_we    = 1'b1;
          lm_waddr = laddr(1'b1, kept_r);
          lm_wdata = sid_r;
          kept_nxt = kept_r + 1'b1;
        end
        i_nxt     = i_r + 1'b1;
        state_nxt = S_SL_LRD;
      end

      // Schedule: retire a task whose slice is used up.
      S_SC_CHK: begin
        if (tq.slice >= sl_len_r) begin
          tm_we          = 1'b1;
          tm_wdata.slice = '0;
          cv_nxt         = 1'b0;
          if (cur_r != 4'd0 && rcnt_r < CNT_FULL) begin
            lm_we    = 1'b1;
            lm_waddr = laddr(1'b0, rcnt_r);
            lm_wdata = cur_r;
            rcnt_nxt = rcnt_r + 1'b1;
          end
        end
        state_nxt = S_SC_POP;
      end
      S_SC_POP: begin
        if (cv_r) begin
          state_nxt = S_OUT_RD;
        end else if (rcnt_r != '0) begin
          lsel_nxt  = 1'b0;
          pop_nxt   = 1'b1;
          k_nxt     = '0;
          found_nxt = 1'b0;
          ret_nxt   = S_SC_SET;
          state_nxt = S_LP_RD;
        end else begin
          cur_nxt   = 4'd0;
          cv_nxt    = 1'b1;
          state_nxt = S_OUT_RD;
        end
      end
      S_SC_SET: begin
        cur_nxt   = head_r;
        cv_nxt    = 1'b1;
        state_nxt = S_OUT_RD;
      end

      // List walk: drop the first match (or the head when popping) and
      // move every later entry down by one.
      S_LP_RD: begin
        if (k_r < lp_cnt) begin
          lm_re     = 1'b1;
          lm_raddr  = laddr(lsel_r, k_r);
          state_nxt = S_LP_CHK;
        end else begin
          if (found_r) begin
            if (lsel_r) begin
              scnt_nxt = scnt_r - 1'b1;
            end else begin
              rcnt_nxt = rcnt_r - 1'b1;
            end
          end
          state_nxt = ret_r;
        end
      end
      S_LP_CHK: begin
        if (!found_r && (pop_r || lm_q == key_r)) begin
          found_nxt = 1'b1;
          head_nxt  = lm_q;
        end else if (found_r) begin
          lm_we    = 1'b1;
          lm_waddr = laddr(lsel_r, k_r - 1'b1);
          lm_wdata = lm_q;
        end
        k_nxt     = k_r + 1'b1;
        state_nxt = S_LP_RD;
      end

      S_RM2: begin
        lsel_nxt  = 1'b1;
        pop_nxt   = 1'b0;
        k_nxt     = '0;
        found_nxt = 1'b0;
        ret_nxt   = S_OUT_RD;
        state_nxt = S_LP_RD;
      end

      // Sleep: load the countdown, then look for the task.
      S_SP_WR: begin
        tm_we          = 1'b1;
        tm_waddr       = IDX_W'(key_r);
        tm_wdata.sleep = 21'(prod_r);
        lsel_nxt       = 1'b0;
        pop_nxt        = 1'b0;
        k_nxt          = '0;
        found_nxt      = 1'b0;
        ret_nxt        = S_SP2;
        state_nxt      = S_LP_RD;
      end
      S_SP2: begin
        if (found_r || (cv_r && cur_r == key_r)) begin
          if (!found_r) begin
            cv_nxt = 1'b0;
          end
          if (scnt_r < CNT_FULL) begin
            lm_we    = 1'b1;
            lm_waddr = laddr(1'b1, scnt_r);
            lm_wdata = key_r;
            scnt_nxt = scnt_r + 1'b1;
          end
          state_nxt = S_OUT_RD;
        end else begin
          lsel_nxt  = 1'b1;
          pop_nxt   = 1'b0;
          k_nxt     = '0;
          found_nxt = 1'b0;
          ret_nxt   = S_SP3;
          state_nxt = S_LP_RD;
        end
      end
      S_SP3: begin
        if (found_r) begin
          if (scnt_r < CNT_FULL) begin
            lm_we    = 1'b1;
            lm_waddr = laddr(1'b1, scnt_r);
            lm_wdata = key_r;
            scnt_nxt = scnt_r + 1'b1;
          end
        end else begin
          status_nxt = rrs_pkg::STATUS_NOT_SCH;
        end
        state_nxt = S_OUT_RD;
      end

      // Fetch the active task's run total and hand over the result.
      S_OUT_RD: begin
        tm_re     = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          oav_nxt       = cv_r;
          oid_nxt       = cv_r ? cur_r : 4'd0;
          ost_nxt       = status_r;
          orun_nxt      = cv_r ? tq.run : 32'd0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      cv_r        <= 1'b0;
      cur_r       <= 4'd0;
      rcnt_r      <= '0;
      scnt_r      <= '0;
      found_r     <= 1'b0;
      pop_r       <= 1'b0;
      lsel_r      <= 1'b0;
      out_valid_r <= 1'b0;
      sl_len_r    <= rrs_pkg::SLICE_LEN_RST;
      tps_r       <= rrs_pkg::TPS_RST;
      tv_r        <= '0;
      tv_q        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      cv_r        <= cv_nxt;
      cur_r       <= cur_nxt;
      rcnt_r      <= rcnt_nxt;
      scnt_r      <= scnt_nxt;
      found_r     <= found_nxt;
      pop_r       <= pop_nxt;
      lsel_r      <= lsel_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        if (cfg_idx == rrs_pkg::CFG_SLICE_LEN) begin
          sl_len_r <= cfg_wdata;
        end else begin
          tps_r <= cfg_wdata[9:0];
        end
      end
      if (tm_we) begin
        tv_r[tm_waddr] <= 1'b1;
      end
      if (tm_re) begin
        tv_q <= tv_r[tm_raddr];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    prod_r   <= prod_nxt;
    i_r      <= i_nxt;
    kept_r   <= kept_nxt;
    k_r      <= k_nxt;
    sid_r    <= sid_nxt;
    head_r   <= head_nxt;
    status_r <= status_nxt;
    oav_r    <= oav_nxt;
    oid_r    <= oid_nxt;
    ost_r    <= ost_nxt;
    orun_r   <= orun_nxt;
  end

endmodule
`default_nettype wire

// ===== hdl/rrs_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrs_ram
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module rrs_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = $clog2(D)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire
